>>> src/tsco_pkg.sv
package tsco_pkg;

  // walker position inside one option
  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_SIZE = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // option kinds
  localparam logic [7:0] KIND_EOL   = 8'd0;
  localparam logic [7:0] KIND_NOP   = 8'd1;
  localparam logic [7:0] KIND_WS    = 8'd3;
  localparam logic [7:0] KIND_SACKP = 8'd4;
  localparam logic [7:0] KIND_TS    = 8'd8;

  // option lengths
  localparam logic [7:0] LEN_MIN   = 8'd2;
  localparam logic [7:0] LEN_WS    = 8'd3;
  localparam logic [7:0] LEN_SACKP = 8'd2;
  localparam logic [7:0] LEN_TS    = 8'd10;

  // body byte index range of the timestamp tsval
  localparam logic [7:0] TSVAL_FIRST = 8'd2;
  localparam logic [7:0] TSVAL_LAST  = 8'd5;
  localparam logic [7:0] WS_INDEX    = 8'd2;

  // window scale limits
  localparam logic [7:0] MAX_WSCALE     = 8'd14;
  localparam logic [3:0] WSCALE_DEFAULT = 4'hf;

  // byte offset saturation point
  localparam logic [5:0] OFFSET_MAX = 6'd63;

endpackage

>>> src/tcp_syn_ts_cookie_option_parser.sv
// TCP SYN option walker that builds a timestamp SYN cookie.
//
// Input stream (in_*): one TCP option byte per transfer. in_tuser marks a real
// byte, in_tdata carries the byte, the segment start flag, the option area
// length, the millisecond clock and the ECE&CWR flag; in_tlast marks the final
// transfer of a segment. Only the final transfer produces a result.
// Output stream (out_*): one transfer per segment with ts_found in out_tuser
// and the cookie tsval and echoed tsecr in out_tdata.
//
// Throughput is one input transfer per cycle while in_tready is high: the
// parse state is updated by a single pass of logic between the input register
// and the result register, which raises out_tvalid for the last byte.
// Reset (rst_n low, synchronous) empties both registers and returns the walker
// to its initial state. When the receiver stalls with a result held, non-last
// bytes keep flowing; a second last byte waits in the input register and
// in_tready drops until the held result is taken.
module tcp_syn_ts_cookie_option_parser
  import tsco_pkg::*;
#(
  parameter int MAX_OPTION_STEPS = 10,
  parameter int MAX_OPTION_BYTES = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] opt_byte, [8] first_item, [14:9] options_len, [46:15] now_ms,
  // [47] ece_and_cwr
  input  logic [47:0] in_tdata,
  // [0] byte_present
  input  logic        in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] cookie_tsval, [63:32] echo_tsecr
  output logic [63:0] out_tdata,
  // [0] ts_found
  output logic        out_tuser
);

  localparam int STEP_W = $clog2(MAX_OPTION_STEPS + 1);
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_OPTION_STEPS);
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);
  localparam logic [5:0] BYTES_MAX = 6'(MAX_OPTION_BYTES);

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_present_r;
  logic        s1_first_r;
  logic        s1_last_r;
  logic [5:0]  s1_len_r;
  logic [31:0] s1_now_r;
  logic        s1_ecn_r;

  logic s1_hold;
  logic s1_fire;

  // parse state
  logic [5:0]        offset_r,  offset_nxt;
  phase_t            phase_r,   phase_nxt;
  logic [7:0]        kind_r,    kind_nxt;
  logic [7:0]        size_r,    size_nxt;
  logic [7:0]        idx_r,     idx_nxt;
  logic [STEP_W-1:0] step_r,    step_nxt;
  logic              stopped_r, stopped_nxt;
  logic [3:0]        scale_r,   scale_nxt;
  logic              sack_r,    sack_nxt;
  logic              ts_r,      ts_nxt;
  logic [31:0]       echo_r,    echo_nxt;
  logic [5:0]        area_r,    area_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        res_ts_r,    res_ts_nxt;
  logic [31:0] res_cookie_r, res_cookie_nxt;
  logic [31:0] res_echo_r,   res_echo_nxt;

  // flow control: only a last byte needs room in the result register
  assign s1_hold   = s1_valid_r && s1_last_r && out_valid_r && !out_tready;
  assign s1_fire   = s1_valid_r && !s1_hold;
  assign in_tready = !s1_hold;

  // input register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r    <= in_tdata[7:0];
      s1_first_r   <= in_tdata[8];
      s1_len_r     <= in_tdata[14:9];
      s1_now_r     <= in_tdata[46:15];
      s1_ecn_r     <= in_tdata[47];
      s1_present_r <= in_tuser;
      s1_last_r    <= in_tlast;
    end
  end

  // option walk, one byte per pass
  always_comb begin
    logic [5:0] pos;
    logic       do_end;

    offset_nxt  = offset_r;
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    size_nxt    = size_r;
    idx_nxt     = idx_r;
    step_nxt    = step_r;
    stopped_nxt = stopped_r;
    scale_nxt   = scale_r;
    sack_nxt    = sack_r;
    ts_nxt      = ts_r;
    echo_nxt    = echo_r;
    area_nxt    = area_r;
    do_end      = 1'b0;

    // segment start clears the walk and latches the area length
    if (s1_first_r) begin
      offset_nxt  = '0;
      phase_nxt   = PH_KIND;
      kind_nxt    = '0;
      size_nxt    = '0;
      idx_nxt     = '0;
      step_nxt    = '0;
      stopped_nxt = 1'b0;
      scale_nxt   = WSCALE_DEFAULT;
      sack_nxt    = 1'b0;
      ts_nxt      = 1'b0;
      echo_nxt    = '0;
      area_nxt    = (s1_len_r > BYTES_MAX) ? BYTES_MAX : s1_len_r;
    end

    pos = offset_nxt;

    if (s1_present_r) begin
      if (offset_nxt != OFFSET_MAX) begin
        offset_nxt = offset_nxt + 6'd1;
      end
      if (!stopped_nxt) begin
        case (phase_nxt)
          PH_KIND: begin
            if (step_nxt >= STEP_MAX || pos >= area_nxt || s1_byte_r == KIND_EOL) begin
              stopped_nxt = 1'b1;
            end else if (s1_byte_r == KIND_NOP) begin
              do_end = 1'b1;
            end else if ({1'b0, pos} + 7'd1 >= {1'b0, area_nxt}) begin
              stopped_nxt = 1'b1;
            end else begin
              kind_nxt  = s1_byte_r;
              phase_nxt = PH_SIZE;
            end
          end
          PH_SIZE: begin
            // the option began one byte before this one
            if (s1_byte_r < LEN_MIN ||
                ({3'b0, pos} - 9'd1 + {1'b0, s1_byte_r}) > {3'b0, area_nxt}) begin
              stopped_nxt = 1'b1;
            end else begin
              size_nxt = s1_byte_r;
              idx_nxt  = 8'd2;
              if (s1_byte_r == LEN_SACKP) begin
                if (kind_nxt == KIND_SACKP) begin
                  sack_nxt = 1'b1;
                end
                do_end = 1'b1;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
          PH_BODY: begin
            if (kind_nxt == KIND_WS && size_nxt == LEN_WS && idx_nxt == WS_INDEX) begin
              scale_nxt = (s1_byte_r < MAX_WSCALE) ? s1_byte_r[3:0] : MAX_WSCALE[3:0];
            end
            if (kind_nxt == KIND_TS && size_nxt == LEN_TS &&
                idx_nxt >= TSVAL_FIRST && idx_nxt <= TSVAL_LAST) begin
              echo_nxt = {echo_nxt[23:0], s1_byte_r};
              if (idx_nxt == TSVAL_LAST) begin
                ts_nxt = 1'b1;
              end
            end
            idx_nxt = idx_nxt + 8'd1;
            if (idx_nxt >= size_nxt) begin
              do_end = 1'b1;
            end
          end
          default: begin
            stopped_nxt = 1'b1;
          end
        endcase
      end
    end

    // close one option step
    if (do_end) begin
      if (step_nxt < STEP_MAX) begin
        step_nxt = step_nxt + STEP_ONE;
      end
      phase_nxt = PH_KIND;
    end
  end

  // cookie for the segment, built from the updated state
  always_comb begin
    res_ts_nxt     = ts_nxt;
    res_cookie_nxt = '0;
    res_echo_nxt   = '0;
    if (ts_nxt) begin
      res_cookie_nxt = {s1_now_r[31:6], s1_ecn_r, sack_nxt, scale_nxt};
      res_echo_nxt   = echo_nxt;
    end
  end

  // parse state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '0;
      phase_r   <= PH_KIND;
      kind_r    <= '0;
      size_r    <= '0;
      idx_r     <= '0;
      step_r    <= '0;
      stopped_r <= 1'b0;
      scale_r   <= WSCALE_DEFAULT;
      sack_r    <= 1'b0;
      ts_r      <= 1'b0;
      echo_r    <= '0;
      area_r    <= '0;
    end else if (s1_fire) begin
      offset_r  <= offset_nxt;
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      size_r    <= size_nxt;
      idx_r     <= idx_nxt;
      step_r    <= step_nxt;
      stopped_r <= stopped_nxt;
      scale_r   <= scale_nxt;
      sack_r    <= sack_nxt;
      ts_r      <= ts_nxt;
      echo_r    <= echo_nxt;
      area_r    <= area_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      res_ts_r     <= res_ts_nxt;
      res_cookie_r <= res_cookie_nxt;
      res_echo_r   <= res_echo_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_ts_r;
  assign out_tdata  = {res_echo_r, res_cookie_r};

  // a held result is never overwritten by the next last byte
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("last byte advanced over a stalled result");

  // no timestamp means an all-zero cookie and tsecr
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 64'd0)
    else $error("nonzero cookie without timestamp");

  // step counter saturates at its limit
  assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_MAX)
    else $error("step counter beyond limit");

endmodule
